// ===== sv/gdfs_pkg.sv =====
`default_nettype none

package gdfs_pkg;

   // result status codes
   typedef enum logic [2:0] {
      STAT_IDLE    = 3'd0,
      STAT_ACCEPT  = 3'd1,
      STAT_REJECT  = 3'd2,
      STAT_EXPAND  = 3'd3,
      STAT_REACHED = 3'd4,
      STAT_PATH    = 3'd5,
      STAT_EMPTY   = 3'd6
   } status_type;

   // direction in which a cell was pushed from its parent
   typedef enum logic [1:0] {
      DIR_NORTH = 2'd0,
      DIR_SOUTH = 2'd1,
      DIR_EAST  = 2'd2,
      DIR_WEST  = 2'd3
   } dir_type;

   localparam logic [5:0] GRID_SIDE_RESET = 6'd20;
   localparam logic [5:0] GRID_SIDE_MIN   = 6'd2;

   typedef struct packed {
      logic take_item;
      logic decide;
      logic nbr;
      logic test;
      logic clear;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic walking;
      logic sweep_last;
      logic dec_reach;
      logic dec_expand;
      logic dir_last;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

// ===== sv/gdfs_ctrl.sv =====
`default_nettype none

module gdfs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gdfs_pkg::sts_type sts,
   output gdfs_pkg::cmd_type cmd
);
   import gdfs_pkg::*;

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_DECIDE = 6'b000100,
      S_NBR    = 6'b001000,
      S_TEST   = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            // a clear after the goal is reached still owes its result beat
            if (sts.sweep_last) begin
               state_in = sts.walking ? S_FINISH : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.take_item = 1'b1;
               state_in      = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            priority if (sts.dec_reach) begin
               state_in = S_CLEAR;
            end else if (sts.dec_expand) begin
               state_in = S_NBR;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_NBR: begin
            cmd.nbr  = 1'b1;
            state_in = S_TEST;
         end
         S_TEST: begin
            cmd.test = 1'b1;
            state_in = sts.dir_last ? S_FINISH : S_NBR;
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   a_decide_from_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE) |-> ($past(state_ff) == S_IDLE))
      else $error("decide entered without an accepted beat");

   a_sweep_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR && sts.sweep_last) |=> (state_ff == S_IDLE || state_ff == S_FINISH))
      else $error("map clear did not finish");

endmodule

`default_nettype wire

// ===== sv/gdfs_datapath.sv =====
`default_nettype none

module gdfs_datapath #(
   parameter int MAX_SIDE = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  gdfs_pkg::cmd_type cmd,
   output gdfs_pkg::sts_type sts,
   input  logic              req_kind,
   input  logic signed [6:0] req_goal_x,
   input  logic signed [6:0] req_goal_y,
   input  logic              csr_wr_en,
   input  logic [5:0]        csr_wr_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_status,
   output logic [4:0]        rsp_cell_x,
   output logic [4:0]        rsp_cell_y,
   output logic              rsp_last
);
   import gdfs_pkg::*;

   localparam int CW        = $clog2(MAX_SIDE);
   localparam int AW        = 2 * CW;
   localparam int MAP_DEPTH = 2 ** AW;
   localparam int CELLS     = MAX_SIDE * MAX_SIDE;
   localparam int SIW       = $clog2(CELLS);
   localparam int KW        = $clog2(CELLS + 1);

   localparam logic [KW-1:0] STACK_FULL = KW'(CELLS);
   localparam logic [CW-1:0] COORD_MAX  = CW'(MAX_SIDE - 1);
   localparam logic [CW:0]   SIDE_MAX   = (CW + 1)'(MAX_SIDE);
   localparam logic [CW:0]   SIDE_MIN   = (CW + 1)'(2);
   localparam logic [6:0]    SIDE_MAX_7 = 7'(MAX_SIDE);

   // memories
   logic          visited_mem [MAP_DEPTH];
   dir_type       parent_mem  [MAP_DEPTH];
   logic [AW-1:0] stack_mem   [CELLS];
   logic          vis_q;
   dir_type       parent_q;
   logic [AW-1:0] stack_q;

   // registers
   logic [5:0]    grid_side_ff;
   logic          item_kind_ff;
   logic [6:0]    item_gx_ff, item_gy_ff;
   logic [CW-1:0] goal_x_ff, goal_y_ff;
   logic          goal_valid_ff;
   logic [CW-1:0] walk_x_ff, walk_y_ff;
   logic          walking_ff;
   logic [KW-1:0] stack_count_ff;
   logic [CW-1:0] cur_x_ff, cur_y_ff;
   dir_type       dir_ff;
   logic [CW-1:0] nbr_x_ff, nbr_y_ff;
   logic          nbr_ok_ff;
   logic [AW-1:0] sweep_ff;
   status_type    res_status_ff;
   logic [CW-1:0] res_x_ff, res_y_ff;
   logic          res_last_ff;
   logic          rsp_valid_ff;
   status_type    rsp_status_ff;
   logic [CW-1:0] rsp_x_ff, rsp_y_ff;
   logic          rsp_last_ff;

   // next values and decode
   logic [CW:0]   side;
   logic          goal_ok;
   logic [CW-1:0] stack_x, stack_y;
   logic          pop, pop_goal, walk_is_start;
   logic [CW-1:0] walk_x_in, walk_y_in;
   logic [CW:0]   nx_w, ny_w;
   logic          bound_ok, nbr_ok_in;
   logic [CW-1:0] nbr_x_in, nbr_y_in;
   status_type    res_status_in;
   logic [CW-1:0] res_x_in, res_y_in;
   logic          res_last_in;
   logic          push;
   logic          vis_we, vis_wd;
   logic [AW-1:0] vis_wa;
   logic          stk_we;
   logic [SIW-1:0] stk_wa, stk_ra;
   logic [AW-1:0] stk_wd;

   always_comb begin
      priority if (grid_side_ff < GRID_SIDE_MIN) begin
         side = SIDE_MIN;
      end else if ({1'b0, grid_side_ff} > SIDE_MAX_7) begin
         side = SIDE_MAX;
      end else begin
         side = (CW + 1)'(grid_side_ff);
      end
   end

   assign goal_ok = !item_gx_ff[6] && !item_gy_ff[6] &&
                    (item_gx_ff < 7'(side)) && (item_gy_ff < 7'(side));

   assign stack_x       = stack_q[CW-1:0];
   assign stack_y       = stack_q[AW-1:CW];
   assign pop           = item_kind_ff && !walking_ff && goal_valid_ff && (stack_count_ff != '0);
   assign pop_goal      = (stack_q == {goal_y_ff, goal_x_ff});
   assign walk_is_start = (walk_x_ff == '0) && (walk_y_ff == '0);

   // step back from the walk cell against its recorded direction
   always_comb begin
      walk_x_in = walk_x_ff;
      walk_y_in = walk_y_ff;
      unique case (parent_q)
         DIR_NORTH: if (walk_y_ff != '0)      walk_y_in = walk_y_ff - CW'(1);
         DIR_SOUTH: if (walk_y_ff < COORD_MAX) walk_y_in = walk_y_ff + CW'(1);
         DIR_EAST:  if (walk_x_ff != '0)      walk_x_in = walk_x_ff - CW'(1);
         DIR_WEST:  if (walk_x_ff < COORD_MAX) walk_x_in = walk_x_ff + CW'(1);
      endcase
   end

   // neighbour of the expanded cell in the current direction
   always_comb begin
      nx_w     = {1'b0, cur_x_ff};
      ny_w     = {1'b0, cur_y_ff};
      bound_ok = 1'b1;
      unique case (dir_ff)
         DIR_NORTH: ny_w = {1'b0, cur_y_ff} + (CW + 1)'(1);
         DIR_SOUTH: begin
            bound_ok = (cur_y_ff != '0);
            ny_w     = {1'b0, cur_y_ff} - (CW + 1)'(1);
         end
         DIR_EAST:  nx_w = {1'b0, cur_x_ff} + (CW + 1)'(1);
         DIR_WEST: begin
            bound_ok = (cur_x_ff != '0);
            nx_w     = {1'b0, cur_x_ff} - (CW + 1)'(1);
         end
      endcase
      nbr_ok_in = bound_ok && (nx_w < side) && (ny_w < side);
      nbr_x_in  = nx_w[CW-1:0];
      nbr_y_in  = ny_w[CW-1:0];
   end

   always_comb begin
      res_status_in = STAT_IDLE;
      res_x_in      = '0;
      res_y_in      = '0;
      res_last_in   = 1'b0;
      priority if (!item_kind_ff) begin
         if (!walking_ff && goal_ok) begin
            res_status_in = STAT_ACCEPT;
            res_x_in      = CW'(item_gx_ff);
            res_y_in      = CW'(item_gy_ff);
         end else begin
            res_status_in = STAT_REJECT;
         end
      end else if (walking_ff) begin
         res_status_in = STAT_PATH;
         res_x_in      = walk_x_ff;
         res_y_in      = walk_y_ff;
         res_last_in   = walk_is_start;
      end else if (!goal_valid_ff) begin
         res_status_in = STAT_IDLE;
      end else if (stack_count_ff == '0) begin
         res_status_in = STAT_EMPTY;
      end else begin
         res_status_in = pop_goal ? STAT_REACHED : STAT_EXPAND;
         res_x_in      = stack_x;
         res_y_in      = stack_y;
      end
   end

   assign push = cmd.test && nbr_ok_ff && !vis_q && (stack_count_ff != STACK_FULL);

   // write ports shared between the clearing sweep and pushes
   assign vis_we = cmd.clear || push;
   assign vis_wa = cmd.clear ? sweep_ff : {nbr_y_ff, nbr_x_ff};
   assign vis_wd = cmd.clear ? (sweep_ff == '0) : 1'b1;
   assign stk_we = push || (cmd.clear && (sweep_ff == '0));
   assign stk_wa = cmd.clear ? '0 : stack_count_ff[SIW-1:0];
   assign stk_wd = cmd.clear ? '0 : {nbr_y_ff, nbr_x_ff};
   assign stk_ra = (stack_count_ff == '0) ? '0 : SIW'(stack_count_ff - KW'(1));

   always_ff @(posedge clock) begin
      if (vis_we) begin
         visited_mem[vis_wa] <= vis_wd;
      end
      vis_q <= visited_mem[{nbr_y_in, nbr_x_in}];
   end

   always_ff @(posedge clock) begin
      if (push) begin
         parent_mem[{nbr_y_ff, nbr_x_ff}] <= dir_ff;
      end
      parent_q <= parent_mem[{walk_y_ff, walk_x_ff}];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_wa] <= stk_wd;
      end
      stack_q <= stack_mem[stk_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_side_ff   <= GRID_SIDE_RESET;
         goal_x_ff      <= '0;
         goal_y_ff      <= '0;
         goal_valid_ff  <= 1'b0;
         walk_x_ff      <= '0;
         walk_y_ff      <= '0;
         walking_ff     <= 1'b0;
         stack_count_ff <= KW'(1);
         dir_ff         <= DIR_NORTH;
         sweep_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            grid_side_ff <= csr_wr_data;
         end
         if (cmd.clear) begin
            sweep_ff <= sweep_ff + AW'(1);
         end
         if (cmd.decide) begin
            priority if (!item_kind_ff) begin
               if (!walking_ff && goal_ok) begin
                  goal_x_ff     <= CW'(item_gx_ff);
                  goal_y_ff     <= CW'(item_gy_ff);
                  goal_valid_ff <= 1'b1;
               end
            end else if (walking_ff) begin
               if (walk_is_start) begin
                  walking_ff <= 1'b0;
               end else begin
                  walk_x_ff <= walk_x_in;
                  walk_y_ff <= walk_y_in;
               end
            end else begin
               if (pop) begin
                  if (pop_goal) begin
                     stack_count_ff <= KW'(1);
                     goal_valid_ff  <= 1'b0;
                     walking_ff     <= 1'b1;
                     walk_x_ff      <= stack_x;
                     walk_y_ff      <= stack_y;
                  end else begin
                     stack_count_ff <= stack_count_ff - KW'(1);
                     dir_ff         <= DIR_NORTH;
                  end
               end
            end
         end
         if (cmd.test) begin
            dir_ff <= dir_type'(2'(dir_ff + 2'd1));
            if (push) begin
               stack_count_ff <= stack_count_ff + KW'(1);
            end
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         item_kind_ff <= req_kind;
         item_gx_ff   <= $unsigned(req_goal_x);
         item_gy_ff   <= $unsigned(req_goal_y);
      end
      if (cmd.decide) begin
         res_status_ff <= res_status_in;
         res_x_ff      <= res_x_in;
         res_y_ff      <= res_y_in;
         res_last_ff   <= res_last_in;
         cur_x_ff      <= stack_x;
         cur_y_ff      <= stack_y;
      end
      if (cmd.nbr) begin
         nbr_x_ff  <= nbr_x_in;
         nbr_y_ff  <= nbr_y_in;
         nbr_ok_ff <= nbr_ok_in;
      end
      if (cmd.finish) begin
         rsp_status_ff <= res_status_ff;
         rsp_x_ff      <= res_x_ff;
         rsp_y_ff      <= res_y_ff;
         rsp_last_ff   <= res_last_ff;
      end
   end

   assign sts.walking    = walking_ff;
   assign sts.sweep_last = &sweep_ff;
   assign sts.dec_reach  = pop && pop_goal;
   assign sts.dec_expand = pop && !pop_goal;
   assign sts.dir_last   = (dir_ff == DIR_WEST);
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_cell_x = 5'(rsp_x_ff);
   assign rsp_cell_y = 5'(rsp_y_ff);
   assign rsp_last   = rsp_last_ff;

   a_walk_xor_goal: assert property (@(posedge clock) disable iff (reset)
      !(walking_ff && goal_valid_ff))
      else $error("walk and live goal at once");

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      stack_count_ff <= STACK_FULL)
      else $error("stack count beyond depth");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.finish))
      else $error("result beat without finish");

endmodule

`default_nettype wire

// ===== sv/grid_dfs_path_finder_core.sv =====
// Depth-first path finder over a square 4-connected grid, starting at cell (0,0).
// Input channel req_*: one beat is either a goal (req_kind 0, req_goal_x/y) or one
// search tick (req_kind 1). Every beat yields exactly one result beat on rsp_*:
// rsp_status, the cell concerned and rsp_last on the start cell of a walk back.
// csr_wr_en/csr_wr_data set the grid side in use (reset 20); write only when idle.
// An expansion takes the four neighbours in turn: each is read from the visited
// map and then pushed, if free, through the visited map's single write port.
// Reaching the goal clears the visited map one entry a cycle, over MAX_SIDE
// rounded up to a power of two, squared, entries (1024 at MAX_SIDE 32).
// One beat is in work at a time; req_stall is high while it is.
// Reset (synchronous) runs the same clearing pass, so req_stall stays high until
// it ends. If rsp_stall holds a waiting result, the next beat is still taken and
// worked on, then waits until the output register frees.
`default_nettype none

module grid_dfs_path_finder_core #(
   parameter int MAX_SIDE = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_kind,
   input  logic signed [6:0] req_goal_x,
   input  logic signed [6:0] req_goal_y,
   input  logic              csr_wr_en,
   input  logic [5:0]        csr_wr_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_status,
   output logic [4:0]        rsp_cell_x,
   output logic [4:0]        rsp_cell_y,
   output logic              rsp_last
);
   import gdfs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   gdfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   gdfs_datapath #(
      .MAX_SIDE (MAX_SIDE)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_kind    (req_kind),
      .req_goal_x  (req_goal_x),
      .req_goal_y  (req_goal_y),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_status  (rsp_status),
      .rsp_cell_x  (rsp_cell_x),
      .rsp_cell_y  (rsp_cell_y),
      .rsp_last    (rsp_last)
   );

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import gdfs_pkg::*;

   localparam int GRID_MAX = 32;
   localparam int CELLS = GRID_MAX * GRID_MAX;
   localparam int PLAN = 0;
   localparam int LIVE = 1;
   localparam logic KIND_GOAL = 1'b0;
   localparam logic KIND_TICK = 1'b1;
   localparam int PHASE_ITEMS = 48;
   localparam int N_PHASES = 12;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 1100;
   localparam int unsigned LIMIT_CYCLES = 2_000_000;

   typedef struct packed {
      logic       kind;
      logic [6:0] gx;
      logic [6:0] gy;
   } search_cmd_type;

   typedef struct packed {
      status_type status;
      logic [4:0] cell_x;
      logic [4:0] cell_y;
      logic       last;
   } path_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_kind = 1'b0;
   logic [6:0] req_goal_x = 7'd0;
   logic [6:0] req_goal_y = 7'd0;
   logic       csr_wr_en = 1'b0;
   logic [5:0] csr_wr_data = 6'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_status;
   logic [4:0] rsp_cell_x;
   logic [4:0] rsp_cell_y;
   logic       rsp_last;

   grid_dfs_path_finder_core #(
      .MAX_SIDE(GRID_MAX)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_kind   (req_kind),
      .req_goal_x (req_goal_x),
      .req_goal_y (req_goal_y),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (rsp_status),
      .rsp_cell_x (rsp_cell_x),
      .rsp_cell_y (rsp_cell_y),
      .rsp_last   (rsp_last)
   );

   always #5 clock = ~clock;

   // Two copies of the search state: PLAN runs ahead while items are generated,
   // LIVE follows the beats the block actually accepts.
   bit         seen_map   [2][CELLS];
   dir_type    came_from  [2][CELLS];
   logic [9:0] dfs_stack  [2][CELLS];
   int         stack_depth[2];
   logic [9:0] goal_at    [2];
   bit         goal_set   [2];
   logic [9:0] trail_at   [2];
   bit         tracing    [2];
   logic [5:0] side_reg   [2];

   search_cmd_type pending_cmds[$];
   path_beat_type  awaited_beats[$];
   path_beat_type  plan_beat = '0;
   search_cmd_type on_wire = '0;

   int planned = 0;
   int beats_in = 0;
   int beats_out = 0;
   int goals_reached = 0;
   int path_cells = 0;
   int empty_seen = 0;
   int mismatches = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int unsigned cycles = 0;

   wire calm = (beats_in >= 500) && (beats_in < 620);

   function automatic int clamp_side(logic [5:0] raw);
      if (raw < 6'd2) return 2;
      if (raw > 6'd32) return GRID_MAX;
      return int'(raw);
   endfunction

   function automatic int side_now(int m);
      return clamp_side(side_reg[m]);
   endfunction

   function automatic path_beat_type make_beat(status_type s, logic [9:0] c, logic l);
      path_beat_type b;
      b.status = s;
      b.cell_x = c[4:0];
      b.cell_y = c[9:5];
      b.last = l;
      return b;
   endfunction

   function automatic void restart_map(int m);
      for (int i = 0; i < CELLS; i++) seen_map[m][i] = 1'b0;
      seen_map[m][0] = 1'b1;
      dfs_stack[m][0] = 10'd0;
      stack_depth[m] = 1;
   endfunction

   function automatic void predictor_reset(int m);
      for (int i = 0; i < CELLS; i++) begin
         came_from[m][i] = DIR_NORTH;
         dfs_stack[m][i] = 10'd0;
      end
      restart_map(m);
      side_reg[m] = GRID_SIDE_RESET;
      goal_at[m] = 10'd0;
      goal_set[m] = 1'b0;
      trail_at[m] = 10'd0;
      tracing[m] = 1'b0;
   endfunction

   function automatic void push_nbr(int m, int nx, int ny, dir_type d, int side);
      int n;
      if (nx < 0 || ny < 0 || nx >= side || ny >= side) return;
      n = ny * GRID_MAX + nx;
      if (seen_map[m][n] || stack_depth[m] >= CELLS) return;
      seen_map[m][n] = 1'b1;
      came_from[m][n] = d;
      dfs_stack[m][stack_depth[m]] = 10'(n);
      stack_depth[m] = stack_depth[m] + 1;
   endfunction

   // undo the push direction to get back to the parent cell
   function automatic logic [9:0] back_step(int m, logic [9:0] c);
      logic [4:0] x;
      logic [4:0] y;
      x = c[4:0];
      y = c[9:5];
      case (came_from[m][c])
         DIR_NORTH: if (y != 5'd0) y = y - 5'd1;
         DIR_SOUTH: if (y != 5'd31) y = y + 5'd1;
         DIR_EAST:  if (x != 5'd0) x = x - 5'd1;
         default:   if (x != 5'd31) x = x + 5'd1;
      endcase
      return {y, x};
   endfunction

   function automatic path_beat_type next_path_beat(int m, search_cmd_type cmd);
      int side;
      int x;
      int y;
      logic [9:0] c;
      side = side_now(m);
      if (cmd.kind == KIND_GOAL) begin
         if (tracing[m] || cmd.gx[6] || cmd.gy[6] || int'(cmd.gx) >= side ||
             int'(cmd.gy) >= side)
            return make_beat(STAT_REJECT, 10'd0, 1'b0);
         goal_at[m] = {cmd.gy[4:0], cmd.gx[4:0]};
         goal_set[m] = 1'b1;
         return make_beat(STAT_ACCEPT, goal_at[m], 1'b0);
      end
      if (tracing[m]) begin
         c = trail_at[m];
         if (c == 10'd0) begin
            tracing[m] = 1'b0;
            return make_beat(STAT_PATH, c, 1'b1);
         end
         trail_at[m] = back_step(m, c);
         return make_beat(STAT_PATH, c, 1'b0);
      end
      if (!goal_set[m]) return make_beat(STAT_IDLE, 10'd0, 1'b0);
      if (stack_depth[m] == 0) return make_beat(STAT_EMPTY, 10'd0, 1'b0);
      c = dfs_stack[m][stack_depth[m] - 1];
      if (c == goal_at[m]) begin
         restart_map(m);
         goal_set[m] = 1'b0;
         tracing[m] = 1'b1;
         trail_at[m] = c;
         return make_beat(STAT_REACHED, c, 1'b0);
      end
      stack_depth[m] = stack_depth[m] - 1;
      x = int'(c[4:0]);
      y = int'(c[9:5]);
      push_nbr(m, x, y + 1, DIR_NORTH, side);
      push_nbr(m, x, y - 1, DIR_SOUTH, side);
      push_nbr(m, x + 1, y, DIR_EAST, side);
      push_nbr(m, x - 1, y, DIR_WEST, side);
      return make_beat(STAT_EXPAND, c, 1'b0);
   endfunction

   // ---------------- stimulus generation ----------------

   task automatic queue_cmd(logic kind, logic [6:0] gx, logic [6:0] gy);
      search_cmd_type cmd;
      cmd.kind = kind;
      cmd.gx = gx;
      cmd.gy = gy;
      pending_cmds.insert(pending_cmds.size(), cmd);
      plan_beat = next_path_beat(PLAN, cmd);
      planned++;
   endtask

   task automatic queue_tick();
      queue_cmd(KIND_TICK, 7'($urandom_range(127)), 7'($urandom_range(127)));
   endtask

   task automatic queue_noise();
      logic [6:0] gx;
      logic [6:0] gy;
      int s;
      s = side_now(PLAN);
      gx = 7'($urandom_range(127));
      gy = 7'($urandom_range(127));
      // a replacement goal already passed over would never be found
      if (!tracing[PLAN] && !gx[6] && !gy[6] && int'(gx) < s && int'(gy) < s &&
          (s > 8 || seen_map[PLAN][{gy[4:0], gx[4:0]}]))
         gx[6] = 1'b1;
      queue_cmd(KIND_GOAL, gx, gy);
   endtask

   // large grids: keep goals in the bottom row so the snake stays short
   task automatic pick_goal(output logic [6:0] gx, output logic [6:0] gy);
      int s;
      s = side_now(PLAN);
      gx = 7'($urandom_range(s - 1));
      gy = (s > 8) ? 7'd0 : 7'($urandom_range(s - 1));
   endtask

   task automatic finish_search(int noise_pct);
      int guard;
      guard = 0;
      while ((goal_set[PLAN] || tracing[PLAN]) && plan_beat.status != STAT_EMPTY &&
             guard < 3000) begin
         if (int'($urandom_range(99)) < noise_pct) queue_noise();
         else queue_tick();
         guard++;
      end
   endtask

   task automatic fill_phase(bit cut_short);
      int first;
      logic [6:0] gx;
      logic [6:0] gy;
      first = planned;
      finish_search(6);
      while (planned - first < PHASE_ITEMS) begin
         if ($urandom_range(9) == 0) queue_tick();
         pick_goal(gx, gy);
         queue_cmd(KIND_GOAL, gx, gy);
         finish_search(6);
      end
      // leave a search open so it carries on under the next, larger side
      if (cut_short) begin
         pick_goal(gx, gy);
         queue_cmd(KIND_GOAL, gx, gy);
         queue_tick();
         queue_tick();
      end
   endtask

   task automatic wait_drain();
      @(negedge clock);
      while (pending_cmds.size() != 0 || req_valid || awaited_beats.size() != 0)
         @(negedge clock);
   endtask

   task automatic set_side(logic [5:0] raw);
      wait_drain();
      repeat (4) @(negedge clock);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= raw;
      side_reg[PLAN] = raw;
      side_reg[LIVE] = raw;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   initial begin : stimulus
      logic [5:0] side_plan [N_PHASES];
      bit cut;
      side_plan = '{6'd4, 6'd2, 6'd7, 6'd3, 6'd32, 6'd0,
                    6'd6, 6'd63, 6'd5, 6'd1, 6'd33, 6'd8};
      predictor_reset(PLAN);
      predictor_reset(LIVE);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, at the reset side of 20
      queue_tick();
      queue_cmd(KIND_GOAL, 7'h40, 7'h40);
      queue_cmd(KIND_GOAL, 7'h3F, 7'h3F);
      queue_cmd(KIND_GOAL, 7'd20, 7'd5);
      queue_cmd(KIND_GOAL, 7'd5, 7'h7F);
      queue_cmd(KIND_GOAL, 7'd0, 7'd0);
      queue_tick();
      queue_cmd(KIND_GOAL, 7'd3, 7'd3);
      queue_tick();
      queue_tick();
      queue_cmd(KIND_GOAL, 7'd19, 7'd19);
      queue_cmd(KIND_GOAL, 7'd2, 7'd0);
      finish_search(0);

      for (int p = 0; p < N_PHASES; p++) begin
         set_side(side_plan[p]);
         cut = (p + 1 < N_PHASES) &&
               clamp_side(side_plan[p + 1]) > clamp_side(side_plan[p]) &&
               clamp_side(side_plan[p + 1]) <= 8;
         fill_phase(cut);
      end

      // exhausted stack: goal moved back onto the start, which is already popped.
      // The block stays in this state, so it comes last.
      set_side(6'd2);
      queue_cmd(KIND_GOAL, 7'd1, 7'd0);
      queue_tick();
      queue_cmd(KIND_GOAL, 7'd0, 7'd0);
      repeat (5) queue_tick();
      queue_cmd(KIND_GOAL, 7'd1, 7'd1);
      queue_tick();

      wait_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Ran %0d request beats over %0d side settings; %0d result beats checked",
               beats_in, N_PHASES + 2, beats_out);
      $display("Goals reached %0d, path cells %0d, empty-stack beats %0d, mismatches %0d",
               goals_reached, path_cells, empty_seen, mismatches);
      if (mismatches == 0 && awaited_beats.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // ---------------- request driver ----------------

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            awaited_beats.insert(awaited_beats.size(), next_path_beat(LIVE, on_wire));
            beats_in <= beats_in + 1;
         end
         if (!req_valid || !req_stall) begin
            if (pending_cmds.size() != 0 && (calm || $urandom_range(99) >= 38)) begin
               on_wire = pending_cmds.pop_front();
               req_valid <= 1'b1;
               req_kind <= on_wire.kind;
               req_goal_x <= on_wire.gx;
               req_goal_y <= on_wire.gy;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- result back-pressure ----------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && beats_in >= 250 && pending_cmds.size() > 20) begin
         // long hold-off so the block backs up onto the request side
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 38);
      end
   end

   // ---------------- result monitor ----------------

   task automatic note_mismatch(string what, path_beat_type want, path_beat_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t %s: want st %0d (%0d,%0d) last %0d, got st %0d (%0d,%0d) last %0d",
                  $realtime, what, want.status, want.cell_x, want.cell_y, want.last,
                  got.status, got.cell_x, got.cell_y, got.last);
   endtask

   always @(posedge clock) begin : monitor
      path_beat_type got;
      path_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.status = status_type'(rsp_status);
         got.cell_x = rsp_cell_x;
         got.cell_y = rsp_cell_y;
         got.last = rsp_last;
         beats_out++;
         if (got.status == STAT_REACHED) goals_reached++;
         if (got.status == STAT_PATH) path_cells++;
         if (got.status == STAT_EMPTY) empty_seen++;
         if (awaited_beats.size() == 0) begin
            note_mismatch("unexpected result beat", '0, got);
         end else begin
            want = awaited_beats.pop_front();
            if (got.status !== want.status || got.cell_x !== want.cell_x ||
                got.cell_y !== want.cell_y || got.last !== want.last)
               note_mismatch("result mismatch", want, got);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("Timed out after %0d cycles with %0d results outstanding",
                  cycles, awaited_beats.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule

// ===== filelist.f =====
sv/gdfs_pkg.sv
sv/gdfs_ctrl.sv
sv/gdfs_datapath.sv
sv/grid_dfs_path_finder_core.sv
sim/tb.sv
